// ----- rtl/block_entropy_meter_macros.svh -----
// Assertion macros shared by the block entropy meter RTL.
`ifndef BLOCK_ENTROPY_METER_MACROS_SVH
`define BLOCK_ENTROPY_METER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BEM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("block_entropy_meter check failed");

// Next-cycle implication, checked outside reset.
`define BEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("block_entropy_meter check failed");

`endif

// ----- rtl/bem_pkg.sv -----
// Types and constants of the block entropy meter.
package bem_pkg;

    localparam int CNT_W  = 32;   // histogram counter and step count width
    localparam int N_W    = 36;   // count times block length
    localparam int FRAC_W = 24;   // fraction bits of logs and probabilities
    localparam int LOG_W  = 30;   // Q6.24 log2 value
    localparam int E_W    = 6;    // exponent of a 36-bit value
    localparam int M_W    = 31;   // log mantissa
    localparam int P_W    = 29;   // clamped probability
    localparam int ENT_W  = 29;   // entropy result
    localparam int ACC_W  = 48;   // signed sum of terms
    localparam int LEN_W  = 4;    // block length register

    localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;
    localparam logic [P_W-1:0]   P_MAX     = 29'h1000_0000;

    localparam logic [1:0] OPC_BIT     = 2'd0;
    localparam logic [1:0] OPC_MEASURE = 2'd1;
    localparam logic [1:0] OPC_CLEAR   = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_UPD, ST_LOGS, ST_RD, ST_RDW,
        ST_GO, ST_CALC, ST_MUL, ST_ACC, ST_FIN, ST_OUT
    } t_state;

    typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_MUL, LG_ADJ} t_log_state;

    typedef enum logic {DV_IDLE, DV_RUN} t_div_state;

endpackage

// ----- rtl/block_entropy_meter.sv -----
// Block entropy meter top level: bit gathering, histogram update, measure sequencer.
// A count command that completes a block reads the block's counter from the histogram
// memory, and the counter is written back in the next cycle, during which no item is
// accepted. A clear command, and reset, sweep all 2^MAX_BLOCK_BITS histogram entries at
// one entry a cycle, during which no item is accepted. A measure with no counted steps
// goes straight to the output with status set. Otherwise it first computes the log2 of the
// step count, then reads each histogram entry in turn and, for each nonzero counter, runs
// the log2 unit (a normalizing shift and 24 squarings) beside the divider. The measure
// covers 2^L entries, where L is the effective block length.
module block_entropy_meter
    import bem_pkg::*;
#(
    parameter int MAX_BLOCK_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data,     // block_length
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [0] bit_value, rest zero
    input  logic [1:0]        s_axis_tuser,   // [1:0] opcode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [28:0] entropy, rest zero
    output logic              m_axis_tuser    // [0] status
);

    localparam int AW    = MAX_BLOCK_BITS;
    localparam int POS_W = $clog2(MAX_BLOCK_BITS);

    `include "block_entropy_meter_macros.svh"

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len;
    logic [AW-1:0]     r_part, n_part;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_steps, n_steps;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_upd_idx, n_upd_idx;
    logic [LOG_W-1:0]  r_ls, n_ls;
    logic [N_W-1:0]    r_n, n_n;
    logic [LOG_W-1:0]  r_absd, n_absd;
    logic              r_neg, n_neg;
    logic [58:0]       r_prod, n_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [ENT_W-1:0]  r_res_ent, n_res_ent;
    logic              r_res_st, n_res_st;
    logic              r_out_valid, n_out_valid;
    logic [ENT_W-1:0]  r_out_ent, n_out_ent;
    logic              r_out_st, n_out_st;

    logic [4:0]        w_h;
    logic [AW:0]       w_mask_full;
    logic [AW-1:0]     w_mask;
    logic [AW-1:0]     w_part_set;
    logic              w_complete;
    logic [AW-1:0]     w_blk_idx;
    logic              w_acc_in;
    logic [1:0]        w_opc;
    logic              w_bit;
    logic              w_last;
    logic              w_out_free;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CNT_W-1:0]  w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [CNT_W-1:0]  w_rdata;
    logic              w_log_start, w_log_busy, w_div_busy;
    logic [N_W-1:0]    w_log_x;
    logic [LOG_W-1:0]  w_log;
    logic [P_W-1:0]    w_p;
    logic [34:0]       w_term;

    // Effective block length, clamped to [4, MAX_BLOCK_BITS].
    always_comb begin
        if (r_len < 4'd4) begin
            w_h = 5'd4;
        end else if ({1'b0, r_len} > 5'(MAX_BLOCK_BITS)) begin
            w_h = 5'(MAX_BLOCK_BITS);
        end else begin
            w_h = {1'b0, r_len};
        end
    end

    assign w_mask_full = (AW+1)'((1 << w_h) - 1);
    assign w_mask = w_mask_full[AW-1:0];
    assign w_opc = s_axis_tuser;
    assign w_bit = s_axis_tdata[0];
    assign w_acc_in = s_axis_tvalid && s_axis_tready;
    assign w_part_set = r_part | (AW'(w_bit) << r_pos);
    assign w_complete = ({1'b0, 5'(r_pos)} + 6'd1) >= {1'b0, w_h};
    assign w_blk_idx = w_part_set & w_mask;
    assign w_last = (r_idx == w_mask);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_term = r_prod[58:24];

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Histogram port control.
    assign w_raddr = (r_state == ST_RD) ? r_idx : w_blk_idx;
    assign w_we = (r_state == ST_CLEAR) || (r_state == ST_UPD);
    assign w_waddr = (r_state == ST_CLEAR) ? r_idx : r_upd_idx;
    assign w_wdata = (r_state == ST_CLEAR) ? '0 :
                     (w_rdata == '1) ? w_rdata : w_rdata + 1'b1;

    assign w_log_start = (r_state == ST_GO) ||
                         (w_acc_in && w_opc == OPC_MEASURE && r_steps != '0);
    assign w_log_x = (r_state == ST_IDLE) ? {{(N_W-CNT_W){1'b0}}, r_steps} : r_n;

    bem_hist_ram #(.ADDR_W(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bem_log2 u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_log_start),
        .i_x     (w_log_x),
        .o_busy  (w_log_busy),
        .o_log   (w_log)
    );

    bem_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_GO),
        .i_n     (r_n),
        .i_s     (r_steps),
        .o_busy  (w_div_busy),
        .o_p     (w_p)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_idx == '1) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_acc_in) begin
                    case (w_opc)
                        OPC_BIT:     if (w_complete) n_state = ST_UPD;
                        OPC_MEASURE: n_state = (r_steps == '0) ? ST_OUT : ST_LOGS;
                        OPC_CLEAR:   n_state = ST_CLEAR;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_UPD:  n_state = ST_IDLE;
            ST_LOGS: if (!w_log_busy) n_state = ST_RD;
            ST_RD:   n_state = ST_RDW;
            ST_RDW: begin
                if (w_rdata != '0) begin
                    n_state = ST_GO;
                end else begin
                    n_state = w_last ? ST_FIN : ST_RD;
                end
            end
            ST_GO:   n_state = ST_CALC;
            ST_CALC: if (!w_log_busy && !w_div_busy) n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = w_last ? ST_FIN : ST_RD;
            ST_FIN:  n_state = ST_OUT;
            ST_OUT:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Register updates.
    always_comb begin
        n_part = r_part;
        n_pos = r_pos;
        n_steps = r_steps;
        n_idx = r_idx;
        n_upd_idx = r_upd_idx;
        n_ls = r_ls;
        n_n = r_n;
        n_absd = r_absd;
        n_neg = r_neg;
        n_prod = r_prod;
        n_acc = r_acc;
        n_res_ent = r_res_ent;
        n_res_st = r_res_st;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_ent = r_out_ent;
        n_out_st = r_out_st;
        case (r_state)
            ST_CLEAR: n_idx = r_idx + 1'b1;
            ST_IDLE: begin
                if (w_acc_in) begin
                    case (w_opc)
                        OPC_BIT: begin
                            if (w_complete) begin
                                n_upd_idx = w_blk_idx;
                                n_part = '0;
                                n_pos = '0;
                            end else begin
                                n_part = w_part_set;
                                n_pos = r_pos + 1'b1;
                            end
                            if (r_steps != '1) n_steps = r_steps + 1'b1;
                        end
                        OPC_MEASURE: begin
                            n_acc = '0;
                            n_idx = '0;
                            n_res_ent = '0;
                            n_res_st = (r_steps == '0);
                        end
                        OPC_CLEAR: begin
                            n_part = '0;
                            n_pos = '0;
                            n_steps = '0;
                            n_idx = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOGS: n_ls = w_log;
            ST_RDW: begin
                n_n = N_W'(w_rdata) * N_W'(w_h);
                if (w_rdata == '0) n_idx = r_idx + 1'b1;
            end
            ST_CALC: begin
                if (w_log <= r_ls) begin
                    n_absd = r_ls - w_log;
                    n_neg = 1'b0;
                end else begin
                    n_absd = w_log - r_ls;
                    n_neg = 1'b1;
                end
            end
            ST_MUL: n_prod = w_p * r_absd;
            ST_ACC: begin
                n_acc = r_neg ? r_acc - ACC_W'(w_term) : r_acc + ACC_W'(w_term);
                n_idx = r_idx + 1'b1;
            end
            ST_FIN: begin
                if (r_acc < 0) begin
                    n_res_ent = '0;
                end else if (r_acc > ACC_W'(P_MAX)) begin
                    n_res_ent = P_MAX;
                end else begin
                    n_res_ent = r_acc[ENT_W-1:0];
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ent = r_res_ent;
                    n_out_st = r_res_st;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_len <= LEN_RESET;
            r_part <= '0;
            r_pos <= '0;
            r_steps <= '0;
            r_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_len <= i_cfg_data;
            r_part <= n_part;
            r_pos <= n_pos;
            r_steps <= n_steps;
            r_idx <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_upd_idx <= n_upd_idx;
        r_ls <= n_ls;
        r_n <= n_n;
        r_absd <= n_absd;
        r_neg <= n_neg;
        r_prod <= n_prod;
        r_acc <= n_acc;
        r_res_ent <= n_res_ent;
        r_res_st <= n_res_st;
        r_out_ent <= n_out_ent;
        r_out_st <= n_out_st;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {{(32-ENT_W){1'b0}}, r_out_ent};
    assign m_axis_tuser = r_out_st;

    `BEM_ASSERT_NEXT(a_blk_upd, w_acc_in && w_opc == OPC_BIT && w_complete, r_state == ST_UPD)
    `BEM_ASSERT_NOW(a_out_from_seq, $rose(m_axis_tvalid), $past(r_state) == ST_OUT)
    `BEM_ASSERT_NEXT(a_nostep, w_acc_in && w_opc == OPC_MEASURE && r_steps == '0, r_res_st)
    `BEM_ASSERT_NOW(a_clr_busy, r_state == ST_CLEAR, !s_axis_tready && w_we)

endmodule

// ----- rtl/bem_hist_ram.sv -----
// Histogram memory: one write port, one read port with registered data.
module bem_hist_ram
    import bem_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [CNT_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CNT_W-1:0]  o_rdata
);

    logic [CNT_W-1:0] r_mem [2**ADDR_W];
    logic [CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bem_log2.sv -----
// Iterative fixed-point log2: normalize one bit a cycle, then 24 squaring steps.
module bem_log2
    import bem_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [N_W-1:0]   i_x,
    output logic             o_busy,
    output logic [LOG_W-1:0] o_log
);

    t_log_state        r_state, n_state;
    logic [N_W-1:0]    r_x, n_x;
    logic [E_W-1:0]    r_e, n_e;
    logic [M_W-1:0]    r_m, n_m;
    logic [2*M_W-1:0]  r_sq, n_sq;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [4:0]        r_cnt, n_cnt;
    logic [31:0]       w_t;

    assign w_t = r_sq[61:30];

    always_comb begin
        n_state = r_state;
        case (r_state)
            LG_IDLE: if (i_start) n_state = LG_NORM;
            LG_NORM: if (r_x[N_W-1] || r_e == '0) n_state = LG_MUL;
            LG_MUL:  n_state = LG_ADJ;
            LG_ADJ:  n_state = (r_cnt == '0) ? LG_IDLE : LG_MUL;
            default: n_state = LG_IDLE;
        endcase
    end

    always_comb begin
        n_x = r_x;
        n_e = r_e;
        n_m = r_m;
        n_sq = r_sq;
        n_frac = r_frac;
        n_cnt = r_cnt;
        case (r_state)
            LG_IDLE: begin
                if (i_start) begin
                    n_x = i_x;
                    n_e = E_W'(N_W - 1);
                    n_frac = '0;
                    n_cnt = 5'd23;
                end
            end
            LG_NORM: begin
                if (r_x[N_W-1] || r_e == '0) begin
                    n_m = r_x[N_W-1:N_W-M_W];
                end else begin
                    n_x = {r_x[N_W-2:0], 1'b0};
                    n_e = r_e - 1'b1;
                end
            end
            LG_MUL: n_sq = r_m * r_m;
            LG_ADJ: begin
                // A square at or above two halves the mantissa and yields a one bit.
                n_m = w_t[31] ? w_t[31:1] : w_t[30:0];
                n_frac = {r_frac[FRAC_W-2:0], w_t[31]};
                n_cnt = r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LG_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x <= n_x;
        r_e <= n_e;
        r_m <= n_m;
        r_sq <= n_sq;
        r_frac <= n_frac;
        r_cnt <= n_cnt;
    end

    assign o_busy = (r_state != LG_IDLE);
    assign o_log = {r_e, r_frac};

endmodule

// ----- rtl/bem_div.sv -----
// Restoring divider for p = (n << 24) / s, one quotient bit a cycle, clamped to 2^28.
module bem_div
    import bem_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [N_W-1:0]   i_n,
    input  logic [CNT_W-1:0] i_s,
    output logic             o_busy,
    output logic [P_W-1:0]   o_p
);

    t_div_state       r_state, n_state;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_s, n_s;
    logic [4:0]       r_low, n_low;
    logic [P_W-1:0]   r_q, n_q;
    logic [4:0]       r_cnt, n_cnt;
    logic [CNT_W:0]   w_rem2;
    logic [CNT_W-1:0] w_top;
    logic             w_ovf;

    assign w_top = {1'b0, i_n[N_W-1:5]};
    assign w_ovf = (w_top >= i_s);
    assign w_rem2 = {r_rem, r_low[4]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE: if (i_start && !w_ovf) n_state = DV_RUN;
            DV_RUN:  if (r_cnt == '0) n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        n_rem = r_rem;
        n_s = r_s;
        n_low = r_low;
        n_q = r_q;
        n_cnt = r_cnt;
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_rem = w_top;
                    n_s = i_s;
                    n_low = i_n[4:0];
                    n_cnt = 5'(P_W - 1);
                    // A quotient of 2^29 or more is clamped right away.
                    n_q = w_ovf ? P_MAX : '0;
                end
            end
            DV_RUN: begin
                if (w_rem2 >= {1'b0, r_s}) begin
                    n_rem = CNT_W'(w_rem2 - {1'b0, r_s});
                    n_q = {r_q[P_W-2:0], 1'b1};
                end else begin
                    n_rem = w_rem2[CNT_W-1:0];
                    n_q = {r_q[P_W-2:0], 1'b0};
                end
                n_low = {r_low[3:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem <= n_rem;
        r_s <= n_s;
        r_low <= n_low;
        r_q <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_busy = (r_state != DV_IDLE);
    assign o_p = (r_q > P_MAX) ? P_MAX : r_q;

endmodule
